### rtl/uart_frame_deframer_crc8_unit_assert.svh
// Assertion macros shared by the serial frame deframer RTL.
`ifndef UART_FRAME_DEFRAMER_CRC8_UNIT_ASSERT_SVH
`define UART_FRAME_DEFRAMER_CRC8_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UFD_ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define UFD_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/ufd_pkg.sv
// Types, constants and the CRC-8 step function of the serial frame deframer.
`timescale 1ns / 1ps
package ufd_pkg;

    localparam int PAYLOAD_MAX_DEF = 32;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LENGTH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_ONE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_START_TWO    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_END_BYTE     = 3'd5;

    localparam logic [15:0] IDLE_TIMEOUT_RST = 16'd20;
    localparam logic [7:0]  MIN_LENGTH_RST   = 8'd1;
    localparam logic [7:0]  MAX_LENGTH_RST   = 8'd33;
    localparam logic [7:0]  START_ONE_RST    = 8'hAA;
    localparam logic [7:0]  START_TWO_RST    = 8'h55;
    localparam logic [7:0]  END_BYTE_RST     = 8'h0D;

    localparam logic [7:0] CRC_POLY = 8'h07;

    localparam logic [1:0] ST_DONE = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;
    localparam logic [1:0] ST_CRC  = 2'd3;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_SYNC2,
        PH_LEN,
        PH_CMD,
        PH_BODY,
        PH_CRC,
        PH_END
    } t_phase;

    typedef enum logic [1:0] {
        B_IDLE,
        B_READ,
        B_SEND
    } t_back_state;

    typedef struct packed {
        logic [7:0]  rx_byte;
        logic [31:0] time_ms;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  command;
        logic [6:0]  payload_length;
        logic [7:0]  data_byte;
        logic        data_valid;
        logic        last;
        logic [31:0] frame_error_count;
        logic [31:0] crc_error_count;
        logic [31:0] good_frame_count;
    } t_out_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  command;
        logic [6:0]  payload_length;
        logic [31:0] frame_error_count;
        logic [31:0] crc_error_count;
        logic [31:0] good_frame_count;
    } t_job;

    function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

### rtl/ufd_stream_if.sv
// Valid/ready stream interface carrying one request payload.
`timescale 1ns / 1ps
interface ufd_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

### rtl/ufd_queue.sv
// Two-entry job queue between the frame parser and the result sequencer.
`timescale 1ns / 1ps
`include "uart_frame_deframer_crc8_unit_assert.svh"
module ufd_queue #(
    parameter type T = ufd_pkg::t_job
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  T     i_din,
    input  logic i_pop,
    output T     o_dout,
    output logic o_full,
    output logic o_empty
);
    T           r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_din;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

    assign o_dout  = r_mem[r_rd_ptr];
    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);

    `UFD_ASSERT_IMPLY(a_no_overflow, i_clk, i_rst_n, i_push, !o_full, "push into full queue")
    `UFD_ASSERT_IMPLY(a_no_underflow, i_clk, i_rst_n, i_pop, !o_empty, "pop from empty queue")
    `UFD_ASSERT_IMPLY(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= 2'd2, "queue count out of range")
endmodule

### rtl/ufd_front.sv
// Frame parser: phase machine, timeout, CRC, counters and payload store writes.
`timescale 1ns / 1ps
module ufd_front #(
    parameter int PAYLOAD_MAX = ufd_pkg::PAYLOAD_MAX_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    ufd_stream_if.sink                                  i_rx,
    input  logic                                        i_cfg_we,
    input  logic [ufd_pkg::CFG_IDX_W-1:0]               i_cfg_idx,
    input  logic [ufd_pkg::CFG_DATA_W-1:0]              i_cfg_wdata,
    output logic                                        o_push,
    output ufd_pkg::t_job                               o_job,
    input  logic                                        i_q_full,
    output logic                                        o_wr_en,
    output logic [$clog2((PAYLOAD_MAX > 1) ? PAYLOAD_MAX : 2)-1:0] o_wr_addr,
    output logic [7:0]                                  o_wr_data,
    input  logic                                        i_drain_done
);
    import ufd_pkg::*;

    localparam int         AddrW       = $clog2((PAYLOAD_MAX > 1) ? PAYLOAD_MAX : 2);
    localparam logic [7:0] PayloadMax8 = 8'(PAYLOAD_MAX);
    localparam logic [7:0] LenLimit    = 8'(PAYLOAD_MAX + 1);

    logic [15:0] r_cfg_timeout;
    logic [7:0]  r_cfg_min_len;
    logic [7:0]  r_cfg_max_len;
    logic [7:0]  r_cfg_start_one;
    logic [7:0]  r_cfg_start_two;
    logic [7:0]  r_cfg_end;

    t_phase      r_phase,     n_phase;
    logic [7:0]  r_frame_len, n_frame_len;
    logic [6:0]  r_bytes,     n_bytes;
    logic [7:0]  r_crc,       n_crc;
    logic [31:0] r_last_time, n_last_time;
    logic [7:0]  r_cmd,       n_cmd;
    logic [31:0] r_fe_cnt,    n_fe_cnt;
    logic [31:0] r_crc_cnt,   n_crc_cnt;
    logic [31:0] r_good_cnt,  n_good_cnt;
    logic        r_pending,   n_pending;

    logic        accept;
    logic [7:0]  rx_b;
    logic [31:0] now;
    logic [31:0] gap;
    logic        timeout;
    t_phase      cur_phase;
    logic [7:0]  base_len;
    logic [6:0]  base_bytes;
    logic [7:0]  base_crc;
    logic [31:0] base_fe;
    logic [6:0]  body_next;
    logic        len_bad;
    logic [7:0]  crc_step;
    logic [7:0]  len_m1;
    logic [6:0]  plen;

    assign rx_b       = i_rx.payload.rx_byte;
    assign now        = i_rx.payload.time_ms;
    assign i_rx.ready = !i_q_full && !(r_pending && (r_phase == PH_BODY));
    assign accept     = i_rx.valid && i_rx.ready;

    assign gap        = now - r_last_time;
    assign timeout    = (r_phase != PH_HUNT) && (gap > {16'd0, r_cfg_timeout});
    assign cur_phase  = timeout ? PH_HUNT : r_phase;
    assign base_len   = timeout ? 8'd0 : r_frame_len;
    assign base_bytes = timeout ? 7'd0 : r_bytes;
    assign base_crc   = timeout ? 8'd0 : r_crc;
    assign base_fe    = r_fe_cnt + 32'(timeout);
    assign body_next  = base_bytes + 7'd1;
    assign crc_step   = crc8_next(base_crc, rx_b);
    assign len_bad    = (rx_b == 8'd0) || (rx_b < r_cfg_min_len) || (rx_b > r_cfg_max_len)
                        || (rx_b > LenLimit);
    assign len_m1     = (base_len >= 8'd1) ? (base_len - 8'd1) : 8'd0;
    assign plen       = (len_m1 > PayloadMax8) ? PayloadMax8[6:0] : len_m1[6:0];

    always_comb begin
        n_phase = r_phase;
        if (accept) begin
            unique case (cur_phase)
                PH_HUNT:  n_phase = (rx_b == r_cfg_start_one) ? PH_SYNC2 : PH_HUNT;
                PH_SYNC2: begin
                    if (rx_b == r_cfg_start_two) begin
                        n_phase = PH_LEN;
                    end else if (rx_b == r_cfg_start_one) begin
                        n_phase = PH_SYNC2;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
                PH_LEN:   n_phase = len_bad ? PH_HUNT : PH_CMD;
                PH_CMD:   n_phase = (base_len <= 8'd1) ? PH_CRC : PH_BODY;
                PH_BODY:  n_phase = ((8'(body_next) + 8'd1) >= base_len) ? PH_CRC : PH_BODY;
                PH_CRC:   n_phase = (rx_b == base_crc) ? PH_END : PH_HUNT;
                PH_END:   n_phase = PH_HUNT;
                default:  n_phase = PH_HUNT;
            endcase
        end
    end

    always_comb begin
        n_frame_len = r_frame_len;
        n_bytes     = r_bytes;
        n_crc       = r_crc;
        n_last_time = r_last_time;
        n_cmd       = r_cmd;
        n_fe_cnt    = r_fe_cnt;
        n_crc_cnt   = r_crc_cnt;
        n_good_cnt  = r_good_cnt;
        n_pending   = r_pending && !i_drain_done;
        o_push      = 1'b0;
        o_wr_en     = 1'b0;
        o_job.status         = ST_BAD;
        o_job.command        = 8'd0;
        o_job.payload_length = 7'd0;
        if (accept) begin
            n_last_time = now;
            n_frame_len = base_len;
            n_bytes     = base_bytes;
            n_crc       = base_crc;
            n_fe_cnt    = base_fe;
            unique case (cur_phase)
                PH_HUNT: begin
                end
                PH_SYNC2: begin
                    if (rx_b != r_cfg_start_two && rx_b != r_cfg_start_one) begin
                        n_frame_len = 8'd0;
                        n_bytes     = 7'd0;
                        n_crc       = 8'd0;
                        n_fe_cnt    = base_fe + 32'd1;
                        o_push      = 1'b1;
                    end
                end
                PH_LEN: begin
                    n_crc   = 8'd0;
                    n_bytes = 7'd0;
                    if (len_bad) begin
                        n_frame_len = 8'd0;
                        n_fe_cnt    = base_fe + 32'd1;
                        o_push      = 1'b1;
                    end else begin
                        n_frame_len = rx_b;
                    end
                end
                PH_CMD: begin
                    n_cmd = rx_b;
                    n_crc = crc_step;
                end
                PH_BODY: begin
                    o_wr_en = ({1'b0, base_bytes} < PayloadMax8);
                    n_bytes = body_next;
                    n_crc   = crc_step;
                end
                PH_CRC: begin
                    if (rx_b != base_crc) begin
                        n_frame_len  = 8'd0;
                        n_bytes      = 7'd0;
                        n_crc        = 8'd0;
                        n_crc_cnt    = r_crc_cnt + 32'd1;
                        o_push       = 1'b1;
                        o_job.status = ST_CRC;
                    end
                end
                PH_END: begin
                    n_frame_len = 8'd0;
                    n_bytes     = 7'd0;
                    n_crc       = 8'd0;
                    o_push      = 1'b1;
                    if (rx_b != r_cfg_end) begin
                        n_fe_cnt = base_fe + 32'd1;
                    end else begin
                        n_good_cnt           = r_good_cnt + 32'd1;
                        o_job.status         = ST_DONE;
                        o_job.command        = r_cmd;
                        o_job.payload_length = plen;
                        if (plen != 7'd0) begin
                            n_pending = 1'b1;
                        end
                    end
                end
                default: begin
                    n_frame_len = 8'd0;
                    n_bytes     = 7'd0;
                    n_crc       = 8'd0;
                    o_push      = 1'b1;
                end
            endcase
        end
        o_job.frame_error_count = n_fe_cnt;
        o_job.crc_error_count   = n_crc_cnt;
        o_job.good_frame_count  = n_good_cnt;
    end

    assign o_wr_addr = base_bytes[AddrW-1:0];
    assign o_wr_data = rx_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_timeout   <= IDLE_TIMEOUT_RST;
            r_cfg_min_len   <= MIN_LENGTH_RST;
            r_cfg_max_len   <= MAX_LENGTH_RST;
            r_cfg_start_one <= START_ONE_RST;
            r_cfg_start_two <= START_TWO_RST;
            r_cfg_end       <= END_BYTE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IDLE_TIMEOUT: r_cfg_timeout   <= i_cfg_wdata;
                CFG_MIN_LENGTH:   r_cfg_min_len   <= i_cfg_wdata[7:0];
                CFG_MAX_LENGTH:   r_cfg_max_len   <= i_cfg_wdata[7:0];
                CFG_START_ONE:    r_cfg_start_one <= i_cfg_wdata[7:0];
                CFG_START_TWO:    r_cfg_start_two <= i_cfg_wdata[7:0];
                CFG_END_BYTE:     r_cfg_end       <= i_cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_frame_len <= 8'd0;
            r_bytes     <= 7'd0;
            r_crc       <= 8'd0;
            r_last_time <= 32'd0;
            r_cmd       <= 8'd0;
            r_fe_cnt    <= 32'd0;
            r_crc_cnt   <= 32'd0;
            r_good_cnt  <= 32'd0;
            r_pending   <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_frame_len <= n_frame_len;
            r_bytes     <= n_bytes;
            r_crc       <= n_crc;
            r_last_time <= n_last_time;
            r_cmd       <= n_cmd;
            r_fe_cnt    <= n_fe_cnt;
            r_crc_cnt   <= n_crc_cnt;
            r_good_cnt  <= n_good_cnt;
            r_pending   <= n_pending;
        end
    end
endmodule

### rtl/ufd_back.sv
// Result sequencer: payload store, drain of completed frames and output register.
`timescale 1ns / 1ps
`include "uart_frame_deframer_crc8_unit_assert.svh"
module ufd_back #(
    parameter int PAYLOAD_MAX = ufd_pkg::PAYLOAD_MAX_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_q_empty,
    input  ufd_pkg::t_job                               i_job,
    output logic                                        o_pop,
    input  logic                                        i_wr_en,
    input  logic [$clog2((PAYLOAD_MAX > 1) ? PAYLOAD_MAX : 2)-1:0] i_wr_addr,
    input  logic [7:0]                                  i_wr_data,
    output logic                                        o_drain_done,
    ufd_stream_if.source                                o_res
);
    import ufd_pkg::*;

    localparam int AddrW = $clog2((PAYLOAD_MAX > 1) ? PAYLOAD_MAX : 2);

    logic [7:0]  mem [PAYLOAD_MAX];
    logic [7:0]  r_rd_data;

    t_back_state r_state,     n_state;
    logic [6:0]  r_idx,       n_idx;
    t_job        r_job,       n_job;
    logic        r_out_valid, n_out_valid;
    t_out_item   r_out,       n_out;

    logic slot_free;
    logic job_is_payload;
    logic is_last;
    logic load;

    assign slot_free      = !r_out_valid || o_res.ready;
    assign job_is_payload = (i_job.status == ST_DONE) && (i_job.payload_length != 7'd0);
    assign is_last        = ((r_idx + 7'd1) == r_job.payload_length);

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= mem[r_idx[AddrW-1:0]];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (!i_q_empty && slot_free && job_is_payload) begin
                    n_state = B_READ;
                end
            end
            B_READ: n_state = B_SEND;
            B_SEND: begin
                if (slot_free) begin
                    n_state = is_last ? B_IDLE : B_READ;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        o_pop        = 1'b0;
        o_drain_done = 1'b0;
        load         = 1'b0;
        n_idx        = r_idx;
        n_job        = r_job;
        n_out        = r_out;
        unique case (r_state)
            B_IDLE: begin
                if (!i_q_empty && slot_free) begin
                    o_pop = 1'b1;
                    if (job_is_payload) begin
                        n_job = i_job;
                        n_idx = 7'd0;
                    end else begin
                        load                    = 1'b1;
                        n_out.status            = i_job.status;
                        n_out.command           = i_job.command;
                        n_out.payload_length    = i_job.payload_length;
                        n_out.data_byte         = 8'd0;
                        n_out.data_valid        = 1'b0;
                        n_out.last              = 1'b1;
                        n_out.frame_error_count = i_job.frame_error_count;
                        n_out.crc_error_count   = i_job.crc_error_count;
                        n_out.good_frame_count  = i_job.good_frame_count;
                    end
                end
            end
            B_READ: begin
            end
            B_SEND: begin
                if (slot_free) begin
                    load                    = 1'b1;
                    n_out.status            = r_job.status;
                    n_out.command           = r_job.command;
                    n_out.payload_length    = r_job.payload_length;
                    n_out.data_byte         = r_rd_data;
                    n_out.data_valid        = 1'b1;
                    n_out.last              = is_last;
                    n_out.frame_error_count = r_job.frame_error_count;
                    n_out.crc_error_count   = r_job.crc_error_count;
                    n_out.good_frame_count  = r_job.good_frame_count;
                    if (is_last) begin
                        o_drain_done = 1'b1;
                    end else begin
                        n_idx = r_idx + 7'd1;
                    end
                end
            end
            default: begin
            end
        endcase
        n_out_valid = load ? 1'b1 : (o_res.ready ? 1'b0 : r_out_valid);
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.payload = r_out;

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_idx       <= 7'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    `UFD_ASSERT_IMPLY(a_drain_job, i_clk, i_rst_n, r_state != B_IDLE, (r_job.status == ST_DONE) && (r_job.payload_length != 7'd0), "drain without a payload frame")
    `UFD_ASSERT_IMPLY(a_idx_range, i_clk, i_rst_n, r_state != B_IDLE, r_idx < r_job.payload_length, "payload index past frame length")
    `UFD_ASSERT_NEXT(a_send_loads, i_clk, i_rst_n, (r_state == B_SEND) && slot_free, r_out_valid && r_out.data_valid, "payload byte not presented")
endmodule

### rtl/uart_frame_deframer_crc8_unit.sv
// Serial frame deframer with CRC-8 check: parser, job queue and result sequencer.
// An error or empty frame result passes through the job queue and then the output register;
// the first payload byte of a completed frame also passes through the payload store read.
// Throughput: one byte request per cycle unless the job queue is full; each payload byte is
// read from the store, then loaded out; next-frame body bytes wait while that payload drains.
// Synchronous active-low reset restores register defaults, clears counters, hunts again.
`timescale 1ns / 1ps
module uart_frame_deframer_crc8_unit #(
    parameter int PAYLOAD_MAX = ufd_pkg::PAYLOAD_MAX_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    ufd_stream_if.sink                     i_rx,
    ufd_stream_if.source                   o_res,
    input  logic                           i_cfg_we,
    input  logic [ufd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ufd_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import ufd_pkg::*;

    localparam int AddrW = $clog2((PAYLOAD_MAX > 1) ? PAYLOAD_MAX : 2);

    logic             q_push;
    t_job             q_din;
    logic             q_pop;
    t_job             q_dout;
    logic             q_full;
    logic             q_empty;
    logic             wr_en;
    logic [AddrW-1:0] wr_addr;
    logic [7:0]       wr_data;
    logic             drain_done;

    ufd_front #(
        .PAYLOAD_MAX (PAYLOAD_MAX)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rx         (i_rx),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_push       (q_push),
        .o_job        (q_din),
        .i_q_full     (q_full),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .i_drain_done (drain_done)
    );

    ufd_queue #(
        .T (t_job)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_din   (q_din),
        .i_pop   (q_pop),
        .o_dout  (q_dout),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    ufd_back #(
        .PAYLOAD_MAX (PAYLOAD_MAX)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .i_job        (q_dout),
        .o_pop        (q_pop),
        .i_wr_en      (wr_en),
        .i_wr_addr    (wr_addr),
        .i_wr_data    (wr_data),
        .o_drain_done (drain_done),
        .o_res        (o_res)
    );
endmodule

### test/uart_frame_deframer_crc8_unit_checker.sv
// Checker that predicts the deframer results from accepted byte requests and compares them.
`timescale 1ns / 1ps
module uart_frame_deframer_crc8_unit_checker #(
    parameter int PAYLOAD_MAX = ufd_pkg::PAYLOAD_MAX_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_rx_valid,
    input  logic                           i_rx_ready,
    input  ufd_pkg::t_in_item              i_rx_payload,
    input  logic                           i_res_valid,
    input  logic                           i_res_ready,
    input  ufd_pkg::t_out_item             i_res_payload,
    input  logic                           i_cfg_we,
    input  logic [ufd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ufd_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_checked
);
    import ufd_pkg::*;

    logic [15:0] idle_limit;
    logic [7:0]  len_floor;
    logic [7:0]  len_ceiling;
    logic [7:0]  sync_one;
    logic [7:0]  sync_two;
    logic [7:0]  close_byte;

    t_phase      ph;
    logic [7:0]  frame_len;
    logic [6:0]  body_count;
    logic [7:0]  crc_acc;
    logic [31:0] prev_time;
    logic [7:0]  cmd_latched;
    logic [7:0]  payload_buf [PAYLOAD_MAX];
    logic [31:0] frame_errs;
    logic [31:0] crc_errs;
    logic [31:0] good_frames;

    t_out_item frame_results_q[$];
    int fails = 0;
    int checked = 0;

    // Bit-serial CRC-8, MSB first, no reflection and no final xor.
    function automatic logic [7:0] fold_crc(input logic [7:0] acc, input logic [7:0] data);
        logic [7:0] c;
        logic       fb;
        int         i;
        c = acc;
        for (i = 7; i >= 0; i--) begin
            fb = c[7] ^ data[i];
            c = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
        end
        return c;
    endfunction

    function automatic void restart_parser();
        ph = PH_HUNT;
        frame_len = 8'd0;
        body_count = 7'd0;
        crc_acc = 8'd0;
    endfunction

    function automatic void post_result(input logic [1:0] st, input logic [7:0] cmd,
                                        input logic [6:0] plen, input logic [7:0] data,
                                        input logic dv, input logic lst);
        t_out_item r;
        r.status = st;
        r.command = cmd;
        r.payload_length = plen;
        r.data_byte = data;
        r.data_valid = dv;
        r.last = lst;
        r.frame_error_count = frame_errs;
        r.crc_error_count = crc_errs;
        r.good_frame_count = good_frames;
        frame_results_q.push_back(r);
    endfunction

    function automatic void deframe_byte(input logic [7:0] b, input logic [31:0] now);
        int plen;
        int k;
        if (ph != PH_HUNT && (now - prev_time) > {16'd0, idle_limit}) begin
            restart_parser();
            frame_errs++;
        end
        prev_time = now;
        case (ph)
            PH_HUNT: begin
                if (b == sync_one) ph = PH_SYNC2;
            end
            PH_SYNC2: begin
                if (b == sync_two) begin
                    ph = PH_LEN;
                end else if (b != sync_one) begin
                    restart_parser();
                    frame_errs++;
                    post_result(ST_BAD, 8'd0, 7'd0, 8'd0, 1'b0, 1'b1);
                end
            end
            PH_LEN: begin
                if (b == 8'd0 || b < len_floor || b > len_ceiling || int'(b) > PAYLOAD_MAX + 1) begin
                    restart_parser();
                    frame_errs++;
                    post_result(ST_BAD, 8'd0, 7'd0, 8'd0, 1'b0, 1'b1);
                end else begin
                    frame_len = b;
                    crc_acc = 8'd0;
                    body_count = 7'd0;
                    ph = PH_CMD;
                end
            end
            PH_CMD: begin
                cmd_latched = b;
                crc_acc = fold_crc(crc_acc, b);
                if (frame_len <= 8'd1) ph = PH_CRC;
                else ph = PH_BODY;
            end
            PH_BODY: begin
                if (int'(body_count) < PAYLOAD_MAX) payload_buf[body_count] = b;
                body_count = body_count + 7'd1;
                crc_acc = fold_crc(crc_acc, b);
                if (int'(body_count) + 1 >= int'(frame_len)) ph = PH_CRC;
            end
            PH_CRC: begin
                if (b != crc_acc) begin
                    restart_parser();
                    crc_errs++;
                    post_result(ST_CRC, 8'd0, 7'd0, 8'd0, 1'b0, 1'b1);
                end else begin
                    ph = PH_END;
                end
            end
            PH_END: begin
                if (b != close_byte) begin
                    restart_parser();
                    frame_errs++;
                    post_result(ST_BAD, 8'd0, 7'd0, 8'd0, 1'b0, 1'b1);
                end else begin
                    plen = (frame_len >= 8'd1) ? int'(frame_len) - 1 : 0;
                    if (plen > PAYLOAD_MAX) plen = PAYLOAD_MAX;
                    restart_parser();
                    good_frames++;
                    if (plen == 0) begin
                        post_result(ST_DONE, cmd_latched, 7'd0, 8'd0, 1'b0, 1'b1);
                    end else begin
                        for (k = 0; k < plen; k++) begin
                            post_result(ST_DONE, cmd_latched, 7'(plen), payload_buf[k], 1'b1,
                                        k == plen - 1);
                        end
                    end
                end
            end
            default: begin
                restart_parser();
                post_result(ST_BAD, 8'd0, 7'd0, 8'd0, 1'b0, 1'b1);
            end
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            idle_limit = IDLE_TIMEOUT_RST;
            len_floor = MIN_LENGTH_RST;
            len_ceiling = MAX_LENGTH_RST;
            sync_one = START_ONE_RST;
            sync_two = START_TWO_RST;
            close_byte = END_BYTE_RST;
            restart_parser();
            prev_time = 32'd0;
            cmd_latched = 8'd0;
            frame_errs = 32'd0;
            crc_errs = 32'd0;
            good_frames = 32'd0;
            frame_results_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_IDLE_TIMEOUT: idle_limit = i_cfg_wdata;
                    CFG_MIN_LENGTH:   len_floor = i_cfg_wdata[7:0];
                    CFG_MAX_LENGTH:   len_ceiling = i_cfg_wdata[7:0];
                    CFG_START_ONE:    sync_one = i_cfg_wdata[7:0];
                    CFG_START_TWO:    sync_two = i_cfg_wdata[7:0];
                    CFG_END_BYTE:     close_byte = i_cfg_wdata[7:0];
                    default: ;
                endcase
            end
            if (i_res_valid && i_res_ready) begin
                if (frame_results_q.size() == 0) begin
                    $error("Result with no expectation waiting: status %0d, data_byte 0x%02h",
                           i_res_payload.status, i_res_payload.data_byte);
                    fails++;
                end else begin
                    want = frame_results_q.pop_front();
                    checked++;
                    check_field("status", want.status, i_res_payload.status);
                    check_field("command", want.command, i_res_payload.command);
                    check_field("payload_length", want.payload_length,
                                i_res_payload.payload_length);
                    check_field("data_byte", want.data_byte, i_res_payload.data_byte);
                    check_field("data_valid", want.data_valid, i_res_payload.data_valid);
                    check_field("last", want.last, i_res_payload.last);
                    check_field("frame_error_count", want.frame_error_count,
                                i_res_payload.frame_error_count);
                    check_field("crc_error_count", want.crc_error_count,
                                i_res_payload.crc_error_count);
                    check_field("good_frame_count", want.good_frame_count,
                                i_res_payload.good_frame_count);
                end
            end
            if (i_rx_valid && i_rx_ready) begin
                deframe_byte(i_rx_payload.rx_byte, i_rx_payload.time_ms);
            end
        end
        o_fail_count <= fails;
        o_pending <= frame_results_q.size();
        o_checked <= checked;
    end

endmodule

### test/uart_frame_deframer_crc8_unit_tb.sv
// Testbench top that feeds framed and corrupted byte requests to the deframer and gives the verdict.
`timescale 1ns / 1ps
module uart_frame_deframer_crc8_unit_tb;
    import ufd_pkg::*;

    typedef enum int {
        FAULT_NONE,
        FAULT_BAD_CRC,
        FAULT_BAD_END,
        FAULT_BAD_SYNC,
        FAULT_TIMEOUT,
        FAULT_DOUBLE_START
    } t_fault;

    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 8;
    localparam int DRAIN_LIMIT     = 20000;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    ufd_stream_if #(.T(t_in_item))  rx_if ();
    ufd_stream_if #(.T(t_out_item)) res_if ();

    int fail_count;
    int pending;
    int checked;

    logic [15:0] cur_timeout;
    logic [7:0]  cur_min;
    logic [7:0]  cur_max;
    logic [7:0]  cur_s1;
    logic [7:0]  cur_s2;
    logic [7:0]  cur_end;
    logic [31:0] now_ms;
    int          bytes_sent = 0;
    int          settings_used = 1;
    bit          sender_eager = 1'b0;
    bit          hold_off_req = 1'b0;

    uart_frame_deframer_crc8_unit uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_rx        (rx_if.sink),
        .o_res       (res_if.source),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    uart_frame_deframer_crc8_unit_checker chk (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_rx_valid    (rx_if.valid),
        .i_rx_ready    (rx_if.ready),
        .i_rx_payload  (rx_if.payload),
        .i_res_valid   (res_if.valid),
        .i_res_ready   (res_if.ready),
        .i_res_payload (res_if.payload),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_wdata   (cfg_wdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // The result side alternates between eager and randomly stalling stretches.
    initial begin
        int  eager_left;
        bit  eager;
        eager_left = 0;
        eager = 1'b0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (eager_left == 0) begin
                eager = ($urandom_range(0, 2) == 0);
                eager_left = $urandom_range(20, 200);
            end
            eager_left--;
            if (hold_off_req) begin
                res_if.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end else if (!eager && $urandom_range(0, 59) == 0) begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(8, 40)) @(posedge clk);
            end else begin
                res_if.ready <= eager ? 1'b1 : ($urandom_range(0, 3) != 0);
            end
        end
    end

    function automatic logic [31:0] byte_spacing();
        if ($urandom_range(0, 9) == 0) return {16'd0, cur_timeout};
        return $urandom_range(0, (cur_timeout > 16'd30) ? 30 : int'(cur_timeout));
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic [31:0] t);
        int pick;
        int gap;
        pick = $urandom_range(0, 99);
        if (sender_eager || pick < 60) gap = 0;
        else if (pick < 90) gap = $urandom_range(1, 3);
        else gap = $urandom_range(8, 30);
        if (gap > 0) begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_if.valid <= 1'b1;
        rx_if.payload.rx_byte <= b;
        rx_if.payload.time_ms <= t;
        @(posedge clk);
        while (!rx_if.ready) @(posedge clk);
        bytes_sent++;
    endtask

    // A frame stops after its length byte when that length can never be accepted.
    task automatic send_frame(input logic [7:0] len, input t_fault fault);
        logic [7:0] seq[$];
        logic [7:0] crc;
        logic [7:0] data;
        int         cut;
        int         i;
        seq.push_back(cur_s1);
        if (fault == FAULT_DOUBLE_START) seq.push_back(cur_s1);
        if (fault == FAULT_BAD_SYNC) begin
            do data = 8'($urandom_range(0, 255)); while (data == cur_s1 || data == cur_s2);
            seq.push_back(data);
        end else begin
            seq.push_back(cur_s2);
            seq.push_back(len);
            if (len >= 8'd1 && int'(len) <= PAYLOAD_MAX_DEF + 1) begin
                data = 8'($urandom_range(0, 255));
                seq.push_back(data);
                crc = chk.fold_crc(8'h00, data);
                for (i = 0; i < int'(len) - 1; i++) begin
                    data = 8'($urandom_range(0, 255));
                    seq.push_back(data);
                    crc = chk.fold_crc(crc, data);
                end
                if (fault == FAULT_BAD_CRC) crc = crc ^ 8'($urandom_range(1, 255));
                seq.push_back(crc);
                if (fault == FAULT_BAD_END) seq.push_back(cur_end ^ 8'($urandom_range(1, 255)));
                else seq.push_back(cur_end);
            end
        end
        cut = (fault == FAULT_TIMEOUT) ? $urandom_range(1, seq.size() - 1) : -1;
        for (i = 0; i < seq.size(); i++) begin
            if (i == cut) now_ms += {16'd0, cur_timeout} + 32'd1 + $urandom_range(0, 1000);
            else now_ms += byte_spacing();
            send_byte(seq[i], now_ms);
        end
    endtask

    task automatic send_random_frame();
        int         pick;
        logic [7:0] len;
        t_fault     fault;
        if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                now_ms += byte_spacing();
                send_byte(8'($urandom_range(0, 255)), now_ms);
            end
        end
        pick = $urandom_range(0, 19);
        if (pick == 0) len = 8'd0;
        else if (pick == 1) len = 8'($urandom_range(34, 255));
        else if (pick == 2) len = 8'd33;
        else len = 8'($urandom_range(1, 8));
        pick = $urandom_range(0, 11);
        if (pick <= 6) fault = FAULT_NONE;
        else if (pick == 7) fault = FAULT_BAD_CRC;
        else if (pick == 8) fault = FAULT_BAD_END;
        else if (pick == 9) fault = FAULT_BAD_SYNC;
        else if (pick == 10) fault = FAULT_TIMEOUT;
        else fault = FAULT_DOUBLE_START;
        send_frame(len, fault);
    endtask

    task automatic random_phase(input int n_bytes);
        int stop;
        stop = bytes_sent + n_bytes;
        while (bytes_sent < stop) begin
            if ($urandom_range(0, 3) == 0) sender_eager = !sender_eager;
            send_random_frame();
        end
    endtask

    task automatic wait_idle();
        rx_if.valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_wdata <= value;
        @(posedge clk);
    endtask

    task automatic apply_settings(input logic [15:0] to, input logic [7:0] mn,
                                  input logic [7:0] mx, input logic [7:0] s1,
                                  input logic [7:0] s2, input logic [7:0] eb);
        wait_idle();
        cfg_write(CFG_IDLE_TIMEOUT, to);
        cfg_write(CFG_MIN_LENGTH, {8'd0, mn});
        cfg_write(CFG_MAX_LENGTH, {8'd0, mx});
        cfg_write(CFG_START_ONE, {8'd0, s1});
        cfg_write(CFG_START_TWO, {8'd0, s2});
        cfg_write(CFG_END_BYTE, {8'd0, eb});
        cfg_we <= 1'b0;
        cur_timeout = to;
        cur_min = mn;
        cur_max = mx;
        cur_s1 = s1;
        cur_s2 = s2;
        cur_end = eb;
        settings_used++;
    endtask

    initial begin
        int waited;
        rst_n <= 1'b0;
        rx_if.valid <= 1'b0;
        rx_if.payload <= '0;
        cfg_we <= 1'b0;
        cfg_idx <= '0;
        cfg_wdata <= '0;
        cur_timeout = IDLE_TIMEOUT_RST;
        cur_min = MIN_LENGTH_RST;
        cur_max = MAX_LENGTH_RST;
        cur_s1 = START_ONE_RST;
        cur_s2 = START_TWO_RST;
        cur_end = END_BYTE_RST;
        now_ms = 32'hFFFF_FFF0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed cases, with the timestamp wrapping early on.
        send_frame(8'd1, FAULT_NONE);
        send_frame(8'd2, FAULT_DOUBLE_START);
        send_frame(8'd2, FAULT_BAD_SYNC);
        send_frame(8'd0, FAULT_NONE);
        send_frame(8'd255, FAULT_NONE);
        send_frame(8'd1, FAULT_BAD_CRC);
        send_frame(8'd1, FAULT_BAD_END);
        send_frame(8'd2, FAULT_TIMEOUT);

        // The result side holds off while a payload frame drains and the next one arrives.
        hold_off_req = 1'b1;
        sender_eager = 1'b1;
        send_frame(8'd17, FAULT_NONE);
        send_frame(8'd2, FAULT_NONE);
        sender_eager = 1'b0;

        random_phase(6);
        apply_settings(16'd0, 8'd1, 8'd255, 8'h00, 8'hFF, 8'hFF);
        random_phase(6);
        apply_settings(16'hFFFF, 8'd255, 8'd1, 8'hFF, 8'h00, 8'h00);
        random_phase(4);
        apply_settings(16'($urandom_range(5, 100)), 8'd3, 8'd12, 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        random_phase(6);

        rx_if.valid <= 1'b0;
        repeat (2) @(posedge clk);
        waited = 0;
        while (pending != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending != 0) $error("%0d expected results never arrived", pending);
        $display("Sent %0d byte requests under %0d register settings; %0d results compared.",
                 bytes_sent, settings_used, checked);
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
